/* rtl/core/mvb_pkg.sv */
// Shared types and constants for the matrix-vector multiply with bias block.
// No dependencies; every other file of the block refers to this package.
package mvb_pkg;

    localparam int MAX_INPUT_LENGTH = 1024;
    localparam int QUEUE_DEPTH      = 4;

    localparam int VALUE_W   = 16;
    localparam int BIAS_W    = 32;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int SUM_W     = 48;
    localparam int ROW_W     = 16;
    localparam int IN_LEN_W  = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_BIAS      = 2'd2;

    typedef struct packed {
        logic [IN_LEN_W-1:0] input_length;
        logic [ROW_W-1:0]    output_length;
        logic                use_bias;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] weight;
        logic [VALUE_W-1:0] vec;
        logic [BIAS_W-1:0]  start_value;
        logic               first;
        logic               row_end;
        logic [ROW_W-1:0]   row_number;
        logic               last_row;
    } mac_item_t;

endpackage

/* rtl/core/mvb_front.sv */
// Front end: accepts beats, keeps the load, column and row positions, holds the
// vector store and issues one multiply-accumulate item per weight. Uses mvb_pkg.
module mvb_front #(
    parameter int MAX_INPUT_LENGTH = mvb_pkg::MAX_INPUT_LENGTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mvb_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [mvb_pkg::VALUE_W-1:0]   value,
    input  logic [mvb_pkg::BIAS_W-1:0]    bias_value,
    output logic                          item_valid,
    input  logic                          item_ready,
    output mvb_pkg::mac_item_t            item
);

    localparam int AW = (MAX_INPUT_LENGTH > 1) ? $clog2(MAX_INPUT_LENGTH) : 1;
    localparam int NW = $clog2(MAX_INPUT_LENGTH + 1);

    logic [mvb_pkg::VALUE_W-1:0] vec_mem [MAX_INPUT_LENGTH];
    logic [mvb_pkg::VALUE_W-1:0] rdata_reg;

    logic [AW-1:0]               lp_reg, lp_next;
    logic [AW-1:0]               cp_reg, cp_next;
    logic [mvb_pkg::ROW_W-1:0]   rp_reg, rp_next;

    logic                        s1_valid_reg, s1_valid_next;
    logic [mvb_pkg::VALUE_W-1:0] s1_weight_reg;
    logic [mvb_pkg::BIAS_W-1:0]  s1_start_reg;
    logic                        s1_first_reg;
    logic                        s1_row_end_reg;
    logic [mvb_pkg::ROW_W-1:0]   s1_row_reg;
    logic                        s1_last_reg;

    logic [mvb_pkg::IN_LEN_W-1:0] len_nz;
    logic [NW-1:0]                n_len;
    logic [mvb_pkg::ROW_W-1:0]    rows;
    logic [AW-1:0]                lp_eff, cp_eff;
    logic                         first, row_end, last_row;
    logic                         accept, accept_load, accept_weight, push;

    assign push          = s1_valid_reg && item_ready;
    assign in_ready      = !s1_valid_reg || item_ready;
    assign accept        = in_valid && in_ready;
    assign accept_load   = accept && (op == mvb_pkg::OP_LOAD);
    assign accept_weight = accept && (op == mvb_pkg::OP_WEIGHT);

    always_comb
    begin
        len_nz = (cfg.input_length == '0) ? mvb_pkg::IN_LEN_W'(1) : cfg.input_length;
        if (32'(len_nz) > 32'(MAX_INPUT_LENGTH))
        begin
            n_len = NW'(MAX_INPUT_LENGTH);
        end
        else
        begin
            n_len = NW'(len_nz);
        end
        rows = (cfg.output_length == '0) ? mvb_pkg::ROW_W'(1) : cfg.output_length;

        lp_eff  = (32'(lp_reg) >= 32'(n_len)) ? '0 : lp_reg;
        lp_next = (32'(lp_eff) + 32'd1 >= 32'(n_len)) ? '0 : lp_eff + AW'(1);

        cp_eff   = (32'(cp_reg) >= 32'(n_len)) ? AW'(n_len - NW'(1)) : cp_reg;
        first    = (cp_eff == '0);
        row_end  = (32'(cp_eff) + 32'd1 >= 32'(n_len));
        cp_next  = row_end ? '0 : cp_eff + AW'(1);
        last_row = ({1'b0, rp_reg} + 17'd1 >= {1'b0, rows});
        rp_next  = row_end ? (last_row ? '0 : rp_reg + mvb_pkg::ROW_W'(1)) : rp_reg;

        s1_valid_next = accept_weight ? 1'b1 : (push ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg       <= '0;
            cp_reg       <= '0;
            rp_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept_load)
            begin
                lp_reg <= lp_next;
            end
            if (accept_weight)
            begin
                cp_reg <= cp_next;
                rp_reg <= rp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_load)
        begin
            vec_mem[lp_eff] <= value;
        end
        if (accept_weight)
        begin
            rdata_reg      <= vec_mem[cp_eff];
            s1_weight_reg  <= value;
            s1_start_reg   <= cfg.use_bias ? bias_value : '0;
            s1_first_reg   <= first;
            s1_row_end_reg <= row_end;
            s1_row_reg     <= rp_reg;
            s1_last_reg    <= last_row;
        end
    end

    assign item_valid       = s1_valid_reg;
    assign item.weight      = s1_weight_reg;
    assign item.vec         = rdata_reg;
    assign item.start_value = s1_start_reg;
    assign item.first       = s1_first_reg;
    assign item.row_end     = s1_row_end_reg;
    assign item.row_number  = s1_row_reg;
    assign item.last_row    = s1_last_reg;

endmodule

/* rtl/core/mvb_queue.sv */
// Short first-in first-out queue of multiply-accumulate items between the
// front and back ends. Uses mvb_pkg for the item type.
module mvb_queue #(
    parameter int DEPTH = mvb_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  mvb_pkg::mac_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output mvb_pkg::mac_item_t pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mvb_pkg::mac_item_t entries [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entries[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/mvb_back.sv */
// Back end: registered 16x16 multiply, saturating 48-bit accumulate and the
// result output register. Uses mvb_pkg for the item type and widths.
module mvb_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  mvb_pkg::mac_item_t                item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mvb_pkg::ROW_W-1:0]         row_number,
    output logic signed [mvb_pkg::SUM_W-1:0]  dot_sum,
    output logic                              last_row
);

    localparam logic signed [mvb_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(mvb_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [mvb_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(mvb_pkg::SUM_W-1){1'b0}}};

    logic                               m_valid_reg;
    logic signed [mvb_pkg::PROD_W-1:0]  m_prod_reg;
    logic [mvb_pkg::BIAS_W-1:0]         m_start_reg;
    logic                               m_first_reg;
    logic                               m_row_end_reg;
    logic [mvb_pkg::ROW_W-1:0]          m_row_reg;
    logic                               m_last_reg;

    logic signed [mvb_pkg::SUM_W-1:0]   acc_reg, acc_next;
    logic                               out_valid_reg;
    logic [mvb_pkg::ROW_W-1:0]          out_row_reg;
    logic signed [mvb_pkg::SUM_W-1:0]   out_sum_reg;
    logic                               out_last_reg;

    logic signed [mvb_pkg::PROD_W-1:0]  prod;
    logic signed [mvb_pkg::SUM_W-1:0]   base;
    logic signed [mvb_pkg::SUM_W:0]     sum_wide;
    logic                               m_adv, pop;

    assign m_adv      = m_valid_reg && (!m_row_end_reg || !out_valid_reg || out_ready);
    assign pop        = item_valid && (!m_valid_reg || m_adv);
    assign item_ready = !m_valid_reg || m_adv;
    assign prod       = $signed(item.weight) * $signed(item.vec);

    always_comb
    begin
        base = m_first_reg ? mvb_pkg::SUM_W'($signed(m_start_reg)) : acc_reg;
        sum_wide = (mvb_pkg::SUM_W+1)'(base) + (mvb_pkg::SUM_W+1)'(m_prod_reg);
        if (sum_wide[mvb_pkg::SUM_W] != sum_wide[mvb_pkg::SUM_W-1])
        begin
            acc_next = sum_wide[mvb_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            acc_next = sum_wide[mvb_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_adv)
            begin
                m_valid_reg <= 1'b0;
            end
            if (m_adv)
            begin
                acc_reg <= acc_next;
            end
            if (m_adv && m_row_end_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_prod_reg    <= prod;
            m_start_reg   <= item.start_value;
            m_first_reg   <= item.first;
            m_row_end_reg <= item.row_end;
            m_row_reg     <= item.row_number;
            m_last_reg    <= item.last_row;
        end
        if (m_adv && m_row_end_reg)
        begin
            out_row_reg  <= m_row_reg;
            out_sum_reg  <= acc_next;
            out_last_reg <= m_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_number = out_row_reg;
    assign dot_sum    = out_sum_reg;
    assign last_row   = out_last_reg;

endmodule

/* rtl/core/matrix_vector_multiply_bias.sv */
// Top level of the fixed-point matrix-vector multiply with per-row bias.
// Holds the configuration registers; depends on mvb_pkg, mvb_front,
// mvb_queue and mvb_back.
//
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    op, value, bias_value
//  out      out_valid / out_ready  row_number, dot_sum, last_row
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input beat is taken per cycle while the queue has room for the front end; a
// weight that ends its row passes from the front-end item register through the
// queue and the multiply register into the output register.
// Reset clears positions, accumulator and registers; the vector store is not
// cleared and needs no clearing pass. A stalled output fills the queue
// before the input side stops taking beats. The configuration port is always ready.
module matrix_vector_multiply_bias #(
    parameter int MAX_INPUT_LENGTH = mvb_pkg::MAX_INPUT_LENGTH,
    parameter int QUEUE_DEPTH      = mvb_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mvb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mvb_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic signed [mvb_pkg::VALUE_W-1:0] value,
    input  logic signed [mvb_pkg::BIAS_W-1:0]  bias_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mvb_pkg::ROW_W-1:0]          row_number,
    output logic signed [mvb_pkg::SUM_W-1:0]   dot_sum,
    output logic                               last_row
);

    mvb_pkg::cfg_t      cfg_reg;
    logic               fq_valid, fq_ready;
    mvb_pkg::mac_item_t fq_item;
    logic               qb_valid, qb_ready;
    mvb_pkg::mac_item_t qb_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_length  <= mvb_pkg::IN_LEN_W'(1);
            cfg_reg.output_length <= mvb_pkg::ROW_W'(1);
            cfg_reg.use_bias      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mvb_pkg::CFG_INPUT_LENGTH:
                begin
                    cfg_reg.input_length <= cfg_data[mvb_pkg::IN_LEN_W-1:0];
                end
                mvb_pkg::CFG_OUTPUT_LENGTH:
                begin
                    cfg_reg.output_length <= cfg_data[mvb_pkg::ROW_W-1:0];
                end
                mvb_pkg::CFG_USE_BIAS:
                begin
                    cfg_reg.use_bias <= cfg_data[0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    mvb_front #(
        .MAX_INPUT_LENGTH (MAX_INPUT_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .value      (value),
        .bias_value (bias_value),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    mvb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    mvb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (qb_valid),
        .item_ready (qb_ready),
        .item       (qb_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_number (row_number),
        .dot_sum    (dot_sum),
        .last_row   (last_row)
    );

endmodule
